// File: rtl/core/itp_pkg.sv
// Shared types, constants and tables of the ISO 8601 timestamp parser.
package itp_pkg;

   localparam int MAX_YEAR_DIGITS_DEF = 5;
   localparam int FRACTION_DIGITS_DEF = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int TS_W = 63;

   // Parsed fields of one text, handed from the parser to the converter.
   typedef struct packed {
      logic signed [17:0] year;
      logic signed [10:0] day;
      logic [18:0]        sec;
      logic [18:0]        off;
      logic               oneg;
      logic [19:0]        frac;
      logic [2:0]         fdig;
      logic               err;
   } rec_type;

   // Days before the first of a month, month given 0-based.
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Scale that pads a fraction of n digits out to six digits.
   function automatic logic [19:0] pad_scale(input logic [2:0] n);
      logic [19:0] r;
      unique case (n)
         3'd0:    r = 20'd1000000;
         3'd1:    r = 20'd100000;
         3'd2:    r = 20'd10000;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd100;
         3'd5:    r = 20'd10;
         default: r = 20'd1;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/iso8601_timestamp_parser.sv
// Top level of the ISO 8601 timestamp parser: character parser, record queue, converter.
// Throughput: one character item per cycle unless the record queue is full; the converter
// takes one timestamp at a time, and a two-entry record queue holds parsed texts for it.
// Result: the last character pushes its record into the queue; an idle converter takes it
// and runs it through recip, year, days, secs, low and high, its registered multiplies.
// Reset: synchronous, active high; clears parser state, queue and any pending result.
module iso8601_timestamp_parser #(
   parameter int MAX_YEAR_DIGITS = itp_pkg::MAX_YEAR_DIGITS_DEF,
   parameter int FRACTION_DIGITS = itp_pkg::FRACTION_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_ch,
   input  logic                            req_last_char,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [itp_pkg::TS_W-1:0] rsp_timestamp_us,
   output logic                            rsp_malformed
);
   import itp_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   rec_type push_rec;
   rec_type head_rec;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   itp_front #(
      .MAX_YEAR_DIGITS(MAX_YEAR_DIGITS),
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .acc_i (accept),
      .ch_i  (req_ch),
      .last_i(req_last_char),
      .push_o(push),
      .rec_o (push_rec)
   );

   itp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (push),
      .push_rec_i(push_rec),
      .pop_i     (pop),
      .head_o    (head_rec),
      .full_o    (q_full),
      .empty_o   (q_empty)
   );

   itp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_i          (head_rec),
      .empty_i         (q_empty),
      .pop_o           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_timestamp_us(rsp_timestamp_us),
      .rsp_malformed   (rsp_malformed)
   );

endmodule

// File: rtl/core/itp_front.sv
// Character parser: takes one character per item and builds the field record of a text.
module itp_front #(
   parameter int MAX_YEAR_DIGITS = itp_pkg::MAX_YEAR_DIGITS_DEF,
   parameter int FRACTION_DIGITS = itp_pkg::FRACTION_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             acc_i,
   input  logic [7:0]       ch_i,
   input  logic             last_i,
   output logic             push_o,
   output itp_pkg::rec_type rec_o
);
   import itp_pkg::*;

   typedef enum logic [4:0] {
      PH_YSTART, PH_YSIGNED, PH_YPLAIN, PH_YSEP, PH_DSTART, PH_DD1, PH_DD2, PH_DD3,
      PH_DAYOPT, PH_DAY2, PH_W1, PH_W2, PH_WSEP, PH_WDAY, PH_AFTERDATE, PH_H1,
      PH_H2, PH_TSEL1, PH_M1, PH_M2, PH_TSEL2, PH_S1, PH_S2, PH_FSEL,
      PH_FRAC, PH_ZONE, PH_OH1, PH_OH2, PH_OSEL, PH_OM1, PH_OM2, PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic               yneg;
      logic [16:0]        yacc;
      logic [15:0]        ydig;
      logic [2:0]         dcnt;
      logic [9:0]         facc;
      logic [6:0]         mhold;
      logic signed [10:0] day;
      logic [18:0]        sec;
      logic [19:0]        frac;
      logic [18:0]        off;
      logic               oneg;
      logic               err;
   } st_type;

   localparam int STEPS = 5;

   st_type st_ff;
   st_type cur;
   st_type fin;
   logic   go;
   logic   redo;

   // Gregorian rule on the last four year digits; the sign does not matter.
   function automatic logic leap_of(input logic [15:0] yd);
      logic [5:0] lo_sum;
      logic [5:0] hi_sum;
      lo_sum = {1'b0, yd[7:4], 1'b0} + {2'b00, yd[3:0]};
      hi_sum = {1'b0, yd[15:12], 1'b0} + {2'b00, yd[11:8]};
      return (lo_sum[1:0] == 2'b00) && ((yd[7:0] != 8'h00) || (hi_sum[1:0] == 2'b00));
   endfunction

   function automatic st_type set_month(input st_type s);
      st_type r;
      r = s;
      if (s.mhold == 7'd0 || s.mhold > 7'd12) begin
         r.err = 1'b1;
      end else begin
         r.day = signed'(11'(days_before(4'(s.mhold[3:0] - 4'd1))))
               + signed'(11'(s.mhold > 7'd2 && leap_of(s.ydig)));
      end
      return r;
   endfunction

   function automatic st_type step(input st_type s, input logic [7:0] c, output logic rd);
      st_type             r;
      logic               isd;
      logic [3:0]         d;
      logic [6:0]         v;
      logic [2:0]         nd;
      logic signed [10:0] w;
      r   = s;
      rd  = 1'b0;
      isd = (c >= 8'h30) && (c <= 8'h39);
      d   = c[3:0];
      v   = 7'(s.facc[3:0]) * 7'd10 + 7'(d);
      nd  = s.dcnt + 3'd1;
      w   = signed'(11'(v)) - 11'sd1;
      unique case (s.phase)
         PH_YSTART: begin
            if (c == "+" || c == "-") begin
               r.yneg  = (c == "-");
               r.phase = PH_YSIGNED;
            end else if (isd) begin
               r.phase = PH_YPLAIN;
               rd      = 1'b1;
            end else begin
               r.err = 1'b1;
            end
         end
         PH_YSIGNED: begin
            if (isd) begin
               r.dcnt = nd;
               if (32'(nd) > MAX_YEAR_DIGITS) begin
                  r.err = 1'b1;
               end else begin
                  r.yacc = 17'(s.yacc * 17'd10) + 17'(d);
                  r.ydig = {s.ydig[11:0], d};
               end
            end else begin
               r.phase = PH_YSEP;
               rd      = 1'b1;
            end
         end
         PH_YPLAIN: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.yacc = 17'(s.yacc * 17'd10) + 17'(d);
               r.ydig = {s.ydig[11:0], d};
               r.dcnt = nd;
               if (nd >= 3'd4) r.phase = PH_YSEP;
            end
         end
         PH_YSEP: begin
            r.dcnt  = 3'd0;
            r.phase = PH_DSTART;
            rd      = (c != "-");
         end
         PH_DSTART: begin
            if (c == "W") begin
               r.phase = PH_W1;
            end else if (isd) begin
               r.facc  = 10'(d);
               r.phase = PH_DD1;
            end else begin
               r.err = 1'b1;
            end
         end
         PH_DD1: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.mhold = v;
               r.phase = PH_DD2;
            end
         end
         PH_DD2: begin
            if (isd) begin
               r.facc  = 10'(d);
               r.phase = PH_DD3;
            end else begin
               r       = set_month(s);
               r.phase = PH_DAYOPT;
               rd      = (c != "-");
            end
         end
         PH_DD3: begin
            if (isd) begin
               r     = set_month(s);
               r.day = r.day + w;
            end else begin
               r.day = signed'(11'(10'(s.mhold) * 10'd10 + s.facc)) - 11'sd1;
               rd    = 1'b1;
            end
            r.phase = PH_AFTERDATE;
         end
         PH_DAYOPT: begin
            if (isd) begin
               r.facc  = 10'(d);
               r.phase = PH_DAY2;
            end else begin
               r.phase = PH_AFTERDATE;
               rd      = 1'b1;
            end
         end
         PH_DAY2: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.day   = s.day + w;
               r.phase = PH_AFTERDATE;
            end
         end
         PH_W1: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.facc  = 10'(d);
               r.phase = PH_W2;
            end
         end
         PH_W2: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.day   = 11'(w * 11'sd7);
               r.phase = PH_WSEP;
            end
         end
         PH_WSEP: begin
            r.phase = PH_WDAY;
            rd      = (c != "-");
         end
         PH_WDAY: begin
            if (isd) r.day = s.day + signed'(11'(d)) - 11'sd1;
            else rd = 1'b1;
            r.phase = PH_AFTERDATE;
         end
         PH_AFTERDATE: begin
            r.phase = (c == "T") ? PH_H1 : PH_DONE;
         end
         PH_H1, PH_M1, PH_S1, PH_OH1, PH_OM1: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               r.facc  = 10'(d);
               r.phase = phase_type'(5'(s.phase) + 5'd1);
            end
         end
         PH_H2, PH_M2, PH_S2, PH_OH2, PH_OM2: begin
            if (!isd) begin
               r.err = 1'b1;
            end else begin
               priority case (s.phase)
                  PH_H2: begin
                     r.sec   = s.sec + 19'(19'(v) * 19'd3600);
                     r.phase = PH_TSEL1;
                  end
                  PH_M2: begin
                     r.sec   = s.sec + 19'(19'(v) * 19'd60);
                     r.phase = PH_TSEL2;
                  end
                  PH_S2: begin
                     r.sec   = s.sec + 19'(v);
                     r.phase = PH_FSEL;
                  end
                  PH_OH2: begin
                     r.off   = s.off + 19'(19'(v) * 19'd3600);
                     r.phase = PH_OSEL;
                  end
                  default: begin
                     r.off   = s.off + 19'(19'(v) * 19'd60);
                     r.phase = PH_DONE;
                  end
               endcase
            end
         end
         PH_TSEL1, PH_TSEL2, PH_OSEL: begin
            if (c == ":" || isd) begin
               rd = isd;
               priority case (s.phase)
                  PH_TSEL1: r.phase = PH_M1;
                  PH_TSEL2: r.phase = PH_S1;
                  default:  r.phase = PH_OM1;
               endcase
            end else if (s.phase == PH_OSEL) begin
               r.err = 1'b1;
            end else begin
               r.phase = PH_ZONE;
               rd      = 1'b1;
            end
         end
         PH_FSEL: begin
            if (c == ".") begin
               r.dcnt  = 3'd0;
               r.phase = PH_FRAC;
            end else begin
               r.phase = PH_ZONE;
               rd      = 1'b1;
            end
         end
         PH_FRAC: begin
            // Padding to six digits is applied later from the digit count.
            if (isd) begin
               if (32'(s.dcnt) < FRACTION_DIGITS) begin
                  r.frac = 20'(s.frac * 20'd10) + 20'(d);
                  r.dcnt = nd;
               end
            end else begin
               r.phase = PH_ZONE;
               rd      = 1'b1;
            end
         end
         PH_ZONE: begin
            if (c == "+" || c == "-") begin
               r.oneg  = (c == "-");
               r.phase = PH_OH1;
            end else begin
               r.phase = PH_DONE;
            end
         end
         PH_DONE: begin
         end
      endcase
      return r;
   endfunction

   // A character may pass through a few phases before it is consumed.
   always_comb begin
      cur  = st_ff;
      go   = !st_ff.err;
      redo = 1'b0;
      for (int i = 0; i < STEPS; i++) begin
         if (go) begin
            cur = step(cur, ch_i, redo);
            go  = redo && !cur.err;
         end
      end
      fin = cur;
      if (!cur.err) begin
         unique case (cur.phase)
            PH_DD2: fin = set_month(cur);
            PH_DD3: fin.day = signed'(11'(10'(cur.mhold) * 10'd10 + cur.facc)) - 11'sd1;
            PH_FRAC, PH_DAYOPT, PH_WSEP, PH_WDAY, PH_AFTERDATE, PH_TSEL1, PH_TSEL2,
            PH_FSEL, PH_ZONE, PH_OSEL, PH_DONE: begin
            end
            default: fin.err = 1'b1;
         endcase
      end
   end

   always_comb begin
      push_o     = acc_i && last_i;
      rec_o.year = fin.yneg ? -signed'({1'b0, fin.yacc}) : signed'({1'b0, fin.yacc});
      rec_o.day  = fin.day;
      rec_o.sec  = fin.sec;
      rec_o.off  = fin.off;
      rec_o.oneg = fin.oneg;
      rec_o.frac = fin.frac;
      rec_o.fdig = fin.dcnt;
      rec_o.err  = fin.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (acc_i) begin
         st_ff <= last_i ? st_type'('0) : cur;
      end
   end

endmodule

// File: rtl/core/itp_queue.sv
// Short queue of parsed records between the parser and the converter.
module itp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  itp_pkg::rec_type push_rec_i,
   input  logic             pop_i,
   output itp_pkg::rec_type head_o,
   output logic             full_o,
   output logic             empty_o
);
   import itp_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            mem_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   wp_ff;
   logic [IDX_W-1:0]   rp_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign full_o  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty_o = (cnt_ff == '0);
   assign head_o  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push_i) mem_ff[wp_ff] <= push_rec_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_i) begin
            wp_ff <= (32'(wp_ff) == QUEUE_DEPTH - 1) ? '0 : IDX_W'(wp_ff + 1'b1);
         end
         if (pop_i) begin
            rp_ff <= (32'(rp_ff) == QUEUE_DEPTH - 1) ? '0 : IDX_W'(rp_ff + 1'b1);
         end
         cnt_ff <= cnt_ff + CNT_W'(push_i) - CNT_W'(pop_i);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i && !pop_i |-> !full_o)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= QUEUE_DEPTH)
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_i && !pop_i |=> !empty_o)
      else $error("queue empty after a write");

endmodule

// File: rtl/core/itp_back.sv
// Converter: turns one parsed record into microseconds over a short multiply sequence.
module itp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  itp_pkg::rec_type                head_i,
   input  logic                            empty_i,
   output logic                            pop_o,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [itp_pkg::TS_W-1:0] rsp_timestamp_us,
   output logic                            rsp_malformed
);
   import itp_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE, B_RECIP, B_YEAR, B_DAYS, B_SECS, B_LOW, B_HIGH
   } bstate_type;

   localparam logic [15:0] RECIP_25 = 16'd41944;

   bstate_type         state_ff;
   rec_type            rec_ff;
   logic [30:0]        prod_ff;
   logic signed [15:0] lsum_ff;
   logic signed [26:0] yr_ff;
   logic signed [27:0] days_ff;
   logic [19:0]        fpad_ff;
   logic signed [45:0] t_ff;
   logic [42:0]        plo_ff;

   logic signed [17:0] ym1;
   logic               yneg;
   logic [16:0]        amag;
   logic [10:0]        q100;
   logic [14:0]        lmag;
   logic signed [20:0] secs;
   logic signed [43:0] phi;
   logic [TS_W-1:0]    total;
   logic               out_free;

   // Leap days before a year use truncating division of year-1 by 4, 100 and 400.
   always_comb begin
      ym1      = rec_ff.year - 18'sd1;
      yneg     = ym1[17];
      amag     = yneg ? 17'(-ym1) : 17'(ym1);
      q100     = 11'(prod_ff >> 20);
      lmag     = amag[16:2] - 15'(q100) + 15'(q100 >> 2);
      secs     = signed'(21'(rec_ff.sec))
               + (rec_ff.oneg ? signed'(21'(rec_ff.off)) : -signed'(21'(rec_ff.off)));
      phi      = 44'(signed'(t_ff[45:23])) * 44'sd1000000;
      total    = TS_W'(TS_W'(phi) << 23) + TS_W'(plo_ff) + TS_W'(fpad_ff);
      out_free = !rsp_valid || rsp_ready;
      pop_o    = (state_ff == B_IDLE) && !empty_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (state_ff == B_HIGH && out_free) rsp_valid <= 1'b1;
         else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty_i) begin
                  rec_ff   <= head_i;
                  state_ff <= B_RECIP;
               end
            end
            B_RECIP: begin
               prod_ff  <= 31'(amag[16:2]) * 31'(RECIP_25);
               state_ff <= B_YEAR;
            end
            B_YEAR: begin
               lsum_ff  <= yneg ? -signed'({1'b0, lmag}) : signed'({1'b0, lmag});
               yr_ff    <= 27'(rec_ff.year) * 27'sd365;
               state_ff <= B_DAYS;
            end
            B_DAYS: begin
               days_ff  <= 28'(rec_ff.day) + 28'(yr_ff) + 28'(lsum_ff);
               fpad_ff  <= 20'(rec_ff.frac * pad_scale(rec_ff.fdig));
               state_ff <= B_SECS;
            end
            B_SECS: begin
               t_ff     <= 46'(days_ff) * 46'sd86400 + 46'(secs);
               state_ff <= B_LOW;
            end
            B_LOW: begin
               plo_ff   <= 43'(t_ff[22:0]) * 43'd1000000;
               state_ff <= B_HIGH;
            end
            B_HIGH: begin
               if (out_free) begin
                  rsp_timestamp_us <= rec_ff.err ? '0 : signed'(total);
                  rsp_malformed    <= rec_ff.err;
                  state_ff         <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop_o |=> state_ff == B_RECIP)
      else $error("record popped without starting a conversion");
   a_result_from_high: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == B_HIGH)
      else $error("result raised outside the final step");
   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_timestamp_us == '0)
      else $error("malformed result carries a timestamp");

endmodule
